>>> src/pun_pkg.sv
`default_nettype none
package pun_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int FRAC_BITS_DEF  = 14;

	// Signed width of every vector that enters or leaves the normalizer.
	localparam int VEC_W = 34;
	// Magnitude width inside the normalizer.
	localparam int MAG_W = 32;
	localparam int PT_W  = 24;

	localparam logic [1:0] FN_APPEND = 2'd0;
	localparam logic [1:0] FN_QUERY  = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;

	typedef struct packed {
		logic start;
		logic tiny_en;
	} uv_ctl_t;

	typedef enum logic [3:0] {
		U_IDLE,
		U_SHIFT,
		U_SQ1,
		U_SQ2,
		U_SQ3,
		U_SQRT,
		U_DINIT,
		U_DIV,
		U_DONE
	} uv_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_READ,
		T_PLAN,
		T_UV1,
		T_UV1W,
		T_UV2,
		T_UV2W,
		T_FIN,
		T_FINW,
		T_EMIT
	} pun_state_t;

endpackage
`default_nettype wire

>>> src/pun_uvec.sv
`default_nettype none
module pun_uvec import pun_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire uv_ctl_t                 ctl,
	input  wire logic signed [VEC_W-1:0] vec_x,
	input  wire logic signed [VEC_W-1:0] vec_y,
	output logic                         done,
	output logic signed [VEC_W-1:0]      res_x,
	output logic signed [VEC_W-1:0]      res_y
);

	localparam int NUM_W = MAG_W + 1 + FRAC_BITS;
	localparam int QW    = FRAC_BITS + 1;
	localparam int CW    = $clog2(QW + 1);
	localparam logic [63:0] TINY_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000000000;

	uv_state_t state_q, state_d;

	logic signed [VEC_W-1:0] x_q, y_q, res_x_q, res_y_q;
	logic [MAG_W-1:0] a_q, b_q;
	logic [63:0] prod_q, acc_q, s_q, r_q, bit_q;
	logic norm_q, sel_q;
	logic [MAG_W:0] rem_q;
	logic [QW-1:0] lo_q, q_q;
	logic [CW-1:0] cnt_q;

	logic [VEC_W-1:0] abs_x, abs_y;
	logic in_zero, big, sq_ge, div_ge, tiny_hit;
	logic [MAG_W-1:0] mul_op, n_val, div_src;
	logic [63:0] sum, sq_trial;
	logic [NUM_W-1:0] num;
	logic [MAG_W:0] div_trial, rem_nx;
	logic [QW-1:0] q_nx;
	logic [VEC_W-1:0] q_ext;
	logic signed [VEC_W-1:0] q_signed;

	always_comb begin
		abs_x    = vec_x[VEC_W-1] ? -vec_x : vec_x;
		abs_y    = vec_y[VEC_W-1] ? -vec_y : vec_y;
		in_zero  = (vec_x == '0) && (vec_y == '0);
		big      = a_q[MAG_W-1] | a_q[MAG_W-2] | b_q[MAG_W-1] | b_q[MAG_W-2];
		mul_op   = (state_q == U_SQ1) ? a_q : b_q;
		sum      = acc_q + prod_q;
		tiny_hit = (sum <= TINY_SQ);
		sq_trial = r_q + bit_q;
		sq_ge    = (s_q >= sq_trial);
		n_val    = r_q[MAG_W-1:0];
		div_src  = sel_q ? b_q : a_q;
		num      = {1'b0, div_src, {FRAC_BITS{1'b0}}}
			+ {{(NUM_W-MAG_W+1){1'b0}}, n_val[MAG_W-1:1]};
		div_trial = {rem_q[MAG_W-1:0], lo_q[QW-1]};
		div_ge    = (div_trial >= {1'b0, n_val});
		rem_nx    = div_ge ? div_trial - {1'b0, n_val} : div_trial;
		q_nx      = {q_q[QW-2:0], div_ge};
		q_ext     = {{(VEC_W-QW){1'b0}}, q_nx};
		if (sel_q) begin
			q_signed = y_q[VEC_W-1] ? -q_ext : q_ext;
		end else begin
			q_signed = x_q[VEC_W-1] ? -q_ext : q_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			U_IDLE: begin
				if (ctl.start) begin
					if (in_zero) begin
						state_d = U_DONE;
					end else if (ctl.tiny_en) begin
						state_d = U_SQ1;
					end else begin
						state_d = U_SHIFT;
					end
				end
			end
			U_SHIFT: begin
				if (big) begin
					state_d = U_SQ1;
				end
			end
			U_SQ1: state_d = U_SQ2;
			U_SQ2: state_d = U_SQ3;
			U_SQ3: begin
				if (norm_q) begin
					state_d = U_SQRT;
				end else if (tiny_hit) begin
					state_d = U_DONE;
				end else begin
					state_d = U_SHIFT;
				end
			end
			U_SQRT: begin
				if (bit_q[0]) begin
					state_d = U_DINIT;
				end
			end
			U_DINIT: state_d = U_DIV;
			U_DIV: begin
				if (cnt_q == CW'(QW - 1)) begin
					state_d = sel_q ? U_DONE : U_DINIT;
				end
			end
			U_DONE: begin
				done    = 1'b1;
				state_d = U_IDLE;
			end
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_op * mul_op;
		case (state_q)
			U_IDLE: begin
				if (ctl.start) begin
					x_q    <= vec_x;
					y_q    <= vec_y;
					a_q    <= abs_x[MAG_W-1:0];
					b_q    <= abs_y[MAG_W-1:0];
					norm_q <= !ctl.tiny_en;
					sel_q  <= 1'b0;
					if (in_zero) begin
						res_x_q <= '0;
						res_y_q <= '0;
					end
				end
			end
			U_SHIFT: begin
				if (!big) begin
					a_q <= {a_q[MAG_W-2:0], 1'b0};
					b_q <= {b_q[MAG_W-2:0], 1'b0};
				end
			end
			U_SQ2: acc_q <= prod_q;
			U_SQ3: begin
				if (norm_q) begin
					s_q   <= sum;
					r_q   <= '0;
					bit_q <= 64'd1 << 62;
				end else if (tiny_hit) begin
					res_x_q <= x_q;
					res_y_q <= y_q;
				end else begin
					norm_q <= 1'b1;
				end
			end
			U_SQRT: begin
				if (sq_ge) begin
					s_q <= s_q - sq_trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			U_DINIT: begin
				rem_q <= {1'b0, num[NUM_W-1:QW]};
				lo_q  <= num[QW-1:0];
				q_q   <= '0;
				cnt_q <= '0;
			end
			U_DIV: begin
				rem_q <= rem_nx;
				lo_q  <= {lo_q[QW-2:0], 1'b0};
				q_q   <= q_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					if (sel_q) begin
						res_y_q <= q_signed;
					end else begin
						res_x_q <= q_signed;
					end
					sel_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res_x = res_x_q;
	assign res_y = res_y_q;

endmodule
`default_nettype wire

>>> src/polyline_unit_normal.sv
// Unit normal at a vertex of a stored polyline.
// One request channel (in_valid/in_ready) carries func, point_x, point_y and
// query_index. An append stores a point while the list is not full and a
// clear empties the list; neither gives a result. A query gives one result
// on the result channel (out_valid/out_ready): normal_x, normal_y and status.
// A query reads four points from the point memory, then runs up to three
// normalizations on one shared unit that shifts one bit a cycle, squares on
// one multiplier, takes the square root one result bit a cycle and divides
// one quotient bit a cycle, in two divisions, x and then y. The time from
// request to result is set by that unit and by how far each vector is
// shifted. A query with fewer than two points answers with status set and a
// zero normal. in_ready is low while a query is at work. The finished result
// sits in an output register; if the receiver stalls, a new request is still
// taken, and the next query waits only to hand over its own result.
// Reset empties the point list and drops any pending result.
`default_nettype none
module polyline_unit_normal import pun_pkg::*; #(
	parameter int MAX_POINTS       = MAX_POINTS_DEF,
	parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             func,
	input  wire logic signed [PT_W-1:0] point_x,
	input  wire logic signed [PT_W-1:0] point_y,
	input  wire logic [7:0]             query_index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [15:0]          normal_x,
	output logic signed [15:0]          normal_y,
	output logic                        status
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IW    = (CNT_W > 8) ? CNT_W : 8;
	localparam int DW    = PT_W + 1;

	pun_state_t state_q, state_d;

	logic [2*PT_W-1:0] mem [MAX_POINTS];
	logic [2*PT_W-1:0] rdata_q, pa_q, pb_q, pc_q, pd_q;
	logic [AW-1:0] raddr;
	logic [CNT_W-1:0] count_q, idx_q, n_m1;
	logic [IW-1:0] qi_ext, nm1_ext;
	logic inter_q, fixed_q;
	logic [2:0] rd_cnt_q;
	logic signed [VEC_W-1:0] ax_q, ay_q, tx_q, ty_q;
	logic out_valid_q, st_q, res_st_q;
	logic [15:0] nx_q, ny_q, res_nx_q, res_ny_q;

	logic accept, closed, dba_zero, dca_zero;
	logic [DW-1:0] dba_x, dba_y, dca_x, dca_y, ddc_x, ddc_y;
	logic signed [VEC_W-1:0] dba_xe, dba_ye, dca_xe, dca_ye, ddc_xe, ddc_ye;
	logic signed [VEC_W-1:0] vec_x, vec_y, uv_x, uv_y, neg_y;
	uv_ctl_t uv_ctl;
	logic uv_done;

	function automatic logic [DW-1:0] pdiff(input logic [PT_W-1:0] p, input logic [PT_W-1:0] q);
		pdiff = {p[PT_W-1], p} - {q[PT_W-1], q};
	endfunction

	always_comb begin
		accept  = in_valid && in_ready;
		n_m1    = count_q - 1'b1;
		qi_ext  = {{(IW-8){1'b0}}, query_index};
		nm1_ext = {{(IW-CNT_W){1'b0}}, n_m1};
		dba_x   = pdiff(pb_q[2*PT_W-1:PT_W], pa_q[2*PT_W-1:PT_W]);
		dba_y   = pdiff(pb_q[PT_W-1:0], pa_q[PT_W-1:0]);
		dca_x   = pdiff(pc_q[2*PT_W-1:PT_W], pa_q[2*PT_W-1:PT_W]);
		dca_y   = pdiff(pc_q[PT_W-1:0], pa_q[PT_W-1:0]);
		ddc_x   = pdiff(pd_q[2*PT_W-1:PT_W], pc_q[2*PT_W-1:PT_W]);
		ddc_y   = pdiff(pd_q[PT_W-1:0], pc_q[PT_W-1:0]);
		dba_xe  = {{(VEC_W-DW){dba_x[DW-1]}}, dba_x};
		dba_ye  = {{(VEC_W-DW){dba_y[DW-1]}}, dba_y};
		dca_xe  = {{(VEC_W-DW){dca_x[DW-1]}}, dca_x};
		dca_ye  = {{(VEC_W-DW){dca_y[DW-1]}}, dca_y};
		ddc_xe  = {{(VEC_W-DW){ddc_x[DW-1]}}, ddc_x};
		ddc_ye  = {{(VEC_W-DW){ddc_y[DW-1]}}, ddc_y};
		closed   = (pa_q == pd_q);
		dba_zero = (dba_x == '0) && (dba_y == '0);
		dca_zero = (dca_x == '0) && (dca_y == '0);
		neg_y    = -uv_y;
	end

	// Interior vertex: cur, next, prev, cur. End vertex: first, second,
	// second to last, last.
	always_comb begin
		case (rd_cnt_q[1:0])
			2'd0: raddr = inter_q ? idx_q[AW-1:0] : '0;
			2'd1: raddr = inter_q ? idx_q[AW-1:0] + 1'b1 : AW'(1);
			2'd2: raddr = inter_q ? idx_q[AW-1:0] - 1'b1 : n_m1[AW-1:0] - 1'b1;
			default: raddr = inter_q ? idx_q[AW-1:0] : n_m1[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && func == FN_APPEND && count_q < CNT_W'(MAX_POINTS)) begin
			mem[count_q[AW-1:0]] <= {point_x, point_y};
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && func == FN_APPEND && count_q < CNT_W'(MAX_POINTS)) begin
				count_q <= count_q + 1'b1;
			end else if (accept && func == FN_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == T_EMIT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		uv_ctl.start   = 1'b0;
		uv_ctl.tiny_en = 1'b0;
		vec_x          = tx_q;
		vec_y          = ty_q;
		case (state_q)
			T_IDLE: begin
				in_ready = 1'b1;
				if (accept && func == FN_QUERY) begin
					state_d = (count_q < CNT_W'(2)) ? T_EMIT : T_READ;
				end
			end
			T_READ: begin
				if (rd_cnt_q == 3'd4) begin
					state_d = T_PLAN;
				end
			end
			T_PLAN: begin
				if (inter_q || (closed && !dba_zero && !dca_zero)) begin
					state_d = T_UV1;
				end else begin
					state_d = T_FIN;
				end
			end
			T_UV1: begin
				uv_ctl.start = 1'b1;
				vec_x        = dba_xe;
				vec_y        = dba_ye;
				state_d      = T_UV1W;
			end
			T_UV1W: begin
				if (uv_done) begin
					state_d = T_UV2;
				end
			end
			T_UV2: begin
				uv_ctl.start = 1'b1;
				vec_x        = dca_xe;
				vec_y        = dca_ye;
				state_d      = T_UV2W;
			end
			T_UV2W: begin
				if (uv_done) begin
					state_d = T_FIN;
				end
			end
			T_FIN: begin
				uv_ctl.start   = 1'b1;
				uv_ctl.tiny_en = fixed_q;
				state_d        = T_FINW;
			end
			T_FINW: begin
				if (uv_done) begin
					state_d = T_EMIT;
				end
			end
			T_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (accept && func == FN_QUERY) begin
					res_nx_q <= '0;
					res_ny_q <= '0;
					res_st_q <= 1'b1;
					rd_cnt_q <= '0;
					idx_q    <= (qi_ext > nm1_ext) ? n_m1 : qi_ext[CNT_W-1:0];
					inter_q  <= (qi_ext != '0) && (qi_ext < nm1_ext);
				end
			end
			T_READ: begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				case (rd_cnt_q)
					3'd1: pa_q <= rdata_q;
					3'd2: pb_q <= rdata_q;
					3'd3: pc_q <= rdata_q;
					3'd4: pd_q <= rdata_q;
					default: ;
				endcase
			end
			T_PLAN: begin
				if (inter_q || closed) begin
					fixed_q <= 1'b1;
					tx_q    <= '0;
					ty_q    <= '0;
				end else begin
					fixed_q <= 1'b0;
					tx_q    <= (idx_q == '0) ? dba_xe : ddc_xe;
					ty_q    <= (idx_q == '0) ? dba_ye : ddc_ye;
				end
			end
			T_UV1W: begin
				if (uv_done) begin
					ax_q <= uv_x;
					ay_q <= uv_y;
				end
			end
			T_UV2W: begin
				if (uv_done) begin
					tx_q <= ax_q - uv_x;
					ty_q <= ay_q - uv_y;
				end
			end
			T_FINW: begin
				if (uv_done) begin
					res_nx_q <= neg_y[15:0];
					res_ny_q <= uv_x[15:0];
					res_st_q <= 1'b0;
				end
			end
			T_EMIT: begin
				if (!out_valid_q || out_ready) begin
					nx_q <= res_nx_q;
					ny_q <= res_ny_q;
					st_q <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	pun_uvec #(
		.FRAC_BITS(NORMAL_FRAC_BITS)
	) u_uvec (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (uv_ctl),
		.vec_x (vec_x),
		.vec_y (vec_y),
		.done  (uv_done),
		.res_x (uv_x),
		.res_y (uv_y)
	);

	assign out_valid = out_valid_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign status    = st_q;

endmodule
`default_nettype wire

>>> dv/tb_polyline_unit_normal.sv
`default_nettype none
module tb_polyline_unit_normal;
	import pun_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int NPTS = 256;
	localparam int FB = 14;
	localparam longint unsigned TINY_SQ = (64'd1 << (2 * FB)) / 64'd10000000000;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic st;
	} normal_res_t;

	typedef struct {
		logic [1:0] f;
		int x;
		int y;
		int idx;
		bit typed;
		normal_res_t res;
	} req_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] func = FN_APPEND;
	logic signed [PT_W-1:0] point_x = '0;
	logic signed [PT_W-1:0] point_y = '0;
	logic [7:0] query_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic status;

	polyline_unit_normal dut (.*);

	longint line_x[NPTS];
	longint line_y[NPTS];
	int line_cnt = 0;
	normal_res_t normals_due[$];
	int mismatches = 0;
	int burst_left = 1;
	bit hold_off = 0;
	int items_sent = 0;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > s) bit_v >>= 2;
		while (bit_v != 0) begin
			if (s >= r + bit_v) begin
				s -= r + bit_v;
				r = (r >> 1) + bit_v;
			end else begin
				r >>= 1;
			end
			bit_v >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint x, input longint y,
			output longint ux, output longint uy);
		longint unsigned a, b, m, n, qa, qb;
		a = x < 0 ? -x : x;
		b = y < 0 ? -y : y;
		if (a == 0 && b == 0) begin
			ux = 0;
			uy = 0;
			return;
		end
		m = a > b ? a : b;
		while (m < (64'd1 << 30)) begin
			a <<= 1;
			b <<= 1;
			m <<= 1;
		end
		n = int_sqrt(a * a + b * b);
		qa = ((a << FB) + n / 2) / n;
		qb = ((b << FB) + n / 2) / n;
		ux = x < 0 ? -longint'(qa) : longint'(qa);
		uy = y < 0 ? -longint'(qb) : longint'(qb);
	endfunction

	function automatic normal_res_t vertex_normal(int idx);
		normal_res_t r;
		int n, i;
		longint tx, ty, ax, ay, bx, by, v1x, v1y, v2x, v2y;
		longint unsigned sq;
		bit unit_tan;
		n = line_cnt;
		if (n < 2) begin
			r.nx = 0;
			r.ny = 0;
			r.st = 1;
			return r;
		end
		i = idx > n - 1 ? n - 1 : idx;
		if (i > 0 && i < n - 1) begin
			unit_vec(line_x[i+1] - line_x[i], line_y[i+1] - line_y[i], ax, ay);
			unit_vec(line_x[i-1] - line_x[i], line_y[i-1] - line_y[i], bx, by);
			tx = ax - bx;
			ty = ay - by;
			unit_tan = 1;
		end else if (line_x[0] == line_x[n-1] && line_y[0] == line_y[n-1]) begin
			v1x = line_x[1] - line_x[0];
			v1y = line_y[1] - line_y[0];
			v2x = line_x[n-2] - line_x[0];
			v2y = line_y[n-2] - line_y[0];
			if ((v1x == 0 && v1y == 0) || (v2x == 0 && v2y == 0)) begin
				tx = 0;
				ty = 0;
			end else begin
				unit_vec(v1x, v1y, ax, ay);
				unit_vec(v2x, v2y, bx, by);
				tx = ax - bx;
				ty = ay - by;
			end
			unit_tan = 1;
		end else if (i == 0) begin
			tx = line_x[1] - line_x[0];
			ty = line_y[1] - line_y[0];
			unit_tan = 0;
		end else begin
			tx = line_x[i] - line_x[i-1];
			ty = line_y[i] - line_y[i-1];
			unit_tan = 0;
		end
		sq = longint'(tx * tx) + longint'(ty * ty);
		if (!(unit_tan && sq <= TINY_SQ)) unit_vec(tx, ty, tx, ty);
		r.nx = 16'(-ty);
		r.ny = 16'(tx);
		r.st = 0;
		return r;
	endfunction

	task automatic send_req(logic [1:0] f, int x, int y, int idx,
			bit typed = 0, normal_res_t res = '{0, 0, 0});
		in_valid <= 1;
		func <= f;
		point_x <= PT_W'(x);
		point_y <= PT_W'(y);
		query_index <= 8'(idx);
		do @(posedge clk); while (!in_ready);
		items_sent++;
		case (f)
			FN_APPEND: begin
				if (line_cnt < NPTS) begin
					line_x[line_cnt] = longint'(signed'(PT_W'(x)));
					line_y[line_cnt] = longint'(signed'(PT_W'(y)));
					line_cnt++;
				end
			end
			FN_CLEAR: line_cnt = 0;
			FN_QUERY: normals_due.push_back(typed ? res : vertex_normal(idx & 8'hff));
			default: ;
		endcase
		if (--burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
	endtask

	req_row_t directed[] = '{
		'{FN_QUERY, 0, 0, 0, 1, '{0, 0, 1}},
		'{FN_APPEND, 0, 0, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 0, 1, '{0, 0, 1}},
		'{FN_APPEND, 256, 0, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 0, 1, '{0, 16384, 0}},
		'{FN_QUERY, 0, 0, 255, 1, '{0, 16384, 0}},
		'{FN_UNUSED, -1, -1, 255, 0, '{0, 0, 0}},
		'{FN_CLEAR, 0, 0, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 8388607, 8388607, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, -8388608, -8388608, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 8388607, -8388608, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 8388607, 8388607, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 1, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 2, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 200, 0, '{0, 0, 0}},
		'{FN_CLEAR, 0, 0, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 5, 5, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 5, 5, 0, 0, '{0, 0, 0}},
		'{FN_APPEND, 5, 5, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 1, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 0, 0, '{0, 0, 0}},
		'{FN_QUERY, 0, 0, 2, 0, '{0, 0, 0}}
	};

	initial begin
		int npts, nq, bx, by, px, py, spread;
		bit closed;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[k])
			send_req(directed[k].f, directed[k].x, directed[k].y, directed[k].idx,
				directed[k].typed, directed[k].res);
		while (items_sent < 1250) begin
			if ($urandom_range(0, 7) != 0) send_req(FN_CLEAR, $urandom, $urandom, $urandom);
			case ($urandom_range(0, 19))
				0: npts = $urandom_range(0, 1);
				1: npts = $urandom_range(250, 262);
				default: npts = $urandom_range(2, 12);
			endcase
			closed = $urandom_range(0, 2) == 0;
			spread = $urandom_range(0, 1) ? 8388607 : $urandom_range(1, 2000);
			bx = $urandom_range(0, 1) ? $signed($urandom) >>> 8 : $urandom_range(0, 4000) - 2000;
			by = $urandom_range(0, 1) ? $signed($urandom) >>> 8 : $urandom_range(0, 4000) - 2000;
			px = bx;
			py = by;
			for (int k = 0; k < npts; k++) begin
				if (closed && k == npts - 1 && npts > 2) begin
					px = bx;
					py = by;
				end else if (k > 0 && $urandom_range(0, 5) != 0) begin
					px = bx + int'($urandom_range(0, 2 * spread)) - spread;
					py = by + int'($urandom_range(0, 2 * spread)) - spread;
				end
				send_req(FN_APPEND, px, py, $urandom);
				if ($urandom_range(0, 40) == 0) send_req(FN_UNUSED, $urandom, $urandom, $urandom);
			end
			nq = $urandom_range(1, 6);
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 1) && npts > 0)
					send_req(FN_QUERY, $urandom, $urandom,
						$urandom_range(0, 1) ? 0 : $urandom_range(0, npts - 1));
				else
					send_req(FN_QUERY, $urandom, $urandom, $urandom_range(0, 255));
			end
		end
		in_valid <= 0;
		while (normals_due.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		repeat (20000) @(posedge clk);
		hold_off <= 1;
		repeat (4000) @(posedge clk);
		hold_off <= 0;
	end

	always @(posedge clk) begin
		case (($time / 20000) % 3)
			0: out_ready <= !hold_off;
			1: out_ready <= !hold_off && $urandom_range(0, 1);
			default: out_ready <= !hold_off && $urandom_range(0, 9) == 0;
		endcase
	end

	always @(posedge clk) begin
		normal_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (normals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
					normal_x, normal_y, status);
			end else begin
				e = normals_due.pop_front();
				if (normal_x !== e.nx || normal_y !== e.ny || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
							e.nx, e.ny, e.st, normal_x, normal_y, status);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
